/* rtl/ccm_pkg.sv */
// ccm_pkg: shared types, codes and constants of the CIGAR coordinate mapper.
// No dependencies; every other file of the block imports it.
package ccm_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [7:0]                    char_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBJ_START  = 3'd0,
    REG_SUBJ_END    = 3'd1,
    REG_QUERY_START = 3'd2,
    REG_QUERY_END   = 3'd3,
    REG_TGT_START   = 3'd4,
    REG_TGT_END     = 3'd5,
    REG_STRAND      = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_MAPPED     = 3'd1,
    ST_BAD_OP     = 3'd2,
    ST_UNRESOLVED = 3'd3,
    ST_BAD_STRAND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    STRAND_FWD = 2'd0,
    STRAND_REV = 2'd1
  } strand_t;

  localparam char_t CH_ZERO  = 8'h30;  // '0'
  localparam char_t CH_NINE  = 8'h39;  // '9'
  localparam char_t CH_EQ    = 8'h3D;  // '='
  localparam char_t CH_X     = 8'h58;  // 'X'
  localparam char_t CH_INS   = 8'h49;  // 'I'
  localparam char_t CH_DEL   = 8'h44;  // 'D'

  // Register file contents
  typedef struct packed {
    coord_t     subj_start;
    coord_t     subj_end;
    coord_t     query_start;
    coord_t     query_end;
    coord_t     tgt_start;
    coord_t     tgt_end;
    logic [1:0] strand;
  } cfg_regs_t;

  // Parser state loaded on the first byte of a string
  typedef struct packed {
    coord_t start_value;
    coord_t end_value;
    logic   start_found;
    logic   end_found;
    coord_t subj_cursor;
    coord_t query_cursor;
  } init_t;

endpackage

/* rtl/ccm_if.sv */
// ccm_if: valid/ready channel interfaces of the CIGAR coordinate mapper.
// Depends on ccm_pkg.
interface ccm_in_if;
  import ccm_pkg::*;
  logic  valid;
  logic  ready;
  char_t cigar_char;
  logic  last_char;
  modport source (output valid, cigar_char, last_char, input ready);
  modport sink   (input valid, cigar_char, last_char, output ready);
endinterface

interface ccm_out_if;
  import ccm_pkg::*;
  logic       valid;
  logic       ready;
  coord_t     mapped_start;
  coord_t     mapped_end;
  logic [2:0] status;
  modport source (output valid, mapped_start, mapped_end, status, input ready);
  modport sink   (input valid, mapped_start, mapped_end, status, output ready);
endinterface

interface ccm_cfg_if;
  import ccm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  coord_t               wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/ccm_offsets.sv */
// ccm_offsets: registers the start-of-string parser state derived from the
// alignment and target registers (overhang and outside-region offsets). Uses ccm_pkg.
module ccm_offsets (
  input  logic               clk,
  input  ccm_pkg::cfg_regs_t cfg,
  output ccm_pkg::init_t     init_r
);
  import ccm_pkg::*;

  init_t  init_nxt;
  logic   rev;

  always_comb begin
    rev = (cfg.strand == STRAND_REV);
    init_nxt              = '0;
    init_nxt.subj_cursor  = rev ? cfg.subj_end : cfg.subj_start;
    init_nxt.query_cursor = cfg.query_start;
    if (cfg.tgt_end < cfg.subj_start) begin
      // whole target before the aligned region
      init_nxt.start_value = rev ? cfg.query_end + (cfg.subj_start - cfg.tgt_end)
                                 : cfg.query_start - (cfg.subj_start - cfg.tgt_start);
      init_nxt.end_value   = rev ? cfg.query_end + (cfg.subj_start - cfg.tgt_start)
                                 : cfg.query_start - (cfg.subj_start - cfg.tgt_end);
      init_nxt.start_found = 1'b1;
      init_nxt.end_found   = 1'b1;
    end else if (cfg.tgt_start >= cfg.subj_end) begin
      // whole target past the aligned region
      init_nxt.start_value = rev ? cfg.query_start - (cfg.tgt_end - cfg.subj_end)
                                 : cfg.query_end + (cfg.tgt_start - cfg.subj_end);
      init_nxt.end_value   = rev ? cfg.query_start - (cfg.tgt_start - cfg.subj_end)
                                 : cfg.query_end + (cfg.tgt_end - cfg.subj_end);
      init_nxt.start_found = 1'b1;
      init_nxt.end_found   = 1'b1;
    end else if (!rev) begin
      if (cfg.tgt_start < cfg.subj_start) begin
        init_nxt.start_value = cfg.query_start - (cfg.subj_start - cfg.tgt_start);
        init_nxt.start_found = 1'b1;
      end
      if (cfg.tgt_end >= cfg.subj_end) begin
        init_nxt.end_value = cfg.query_end + (cfg.tgt_end - cfg.subj_end);
        init_nxt.end_found = 1'b1;
      end
    end else begin
      if (cfg.tgt_start < cfg.subj_start) begin
        init_nxt.end_value = cfg.query_end + (cfg.subj_start - cfg.tgt_start);
        init_nxt.end_found = 1'b1;
      end
      if (cfg.tgt_end >= cfg.subj_end) begin
        init_nxt.start_value = cfg.query_start - (cfg.tgt_end - cfg.subj_end)
                               - coord_t'(1);
        init_nxt.start_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    init_r <= init_nxt;
  end

endmodule

/* rtl/cigar_coordinate_mapper.sv */
// cigar_coordinate_mapper: top level. Parses a CIGAR string one byte per
// request and lifts a target subject interval onto query coordinates.
// Depends on ccm_pkg, ccm_if (interfaces) and ccm_offsets.
//
//  channel | dir | payload                              | handshake
//  --------+-----+--------------------------------------+------------------
//  in_ch   | in  | cigar_char[7:0], last_char           | valid & ready
//  out_ch  | out | mapped_start, mapped_end, status[2:0]| valid & ready
//  cfg_ch  | in  | reg_index[2:0], wr_data              | valid & ready (=1)
//
// Each accepted byte goes into an input register, then takes one pass through
// the parse logic into the result register.
// A new byte is taken every cycle unless out_ch stalls; the feedback loop is
// the cursor/run update. Reset (rst_n low, synchronous) clears the valid,
// control and configuration registers and rearms the parser. A stall on
// out_ch holds the result register and the input register. Configuration
// writes take effect for strings whose first byte is accepted after the write.
module cigar_coordinate_mapper (
  input logic clk,
  input logic rst_n,
  ccm_in_if.sink    in_ch,
  ccm_out_if.source out_ch,
  ccm_cfg_if.sink   cfg_ch
);
  import ccm_pkg::*;

  // configuration registers
  cfg_regs_t cfg_r;
  init_t     init_r;

  // input stage
  logic  s1_valid_r;
  char_t s1_char_r;
  logic  s1_last_r;
  logic  s1_go;
  logic  s1_fire;

  // parser state
  coord_t  run_r, run_nxt;
  coord_t  scur_r, scur_nxt;
  coord_t  qcur_r, qcur_nxt;
  coord_t  sval_r, sval_nxt;
  coord_t  eval_r, eval_nxt;
  logic    sfound_r, sfound_nxt;
  logic    efound_r, efound_nxt;
  logic    first_r, first_nxt;
  status_t held_r, held_nxt;

  // result register
  logic    out_valid_r;
  coord_t  out_start_r, out_start_nxt;
  coord_t  out_end_r, out_end_nxt;
  status_t out_status_r, out_status_nxt;

  // step temporaries
  logic   rev, bad_strand, is_digit, is_match, is_del, is_ins;
  char_t  dig;
  coord_t hi, lo, run_x10;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.reg_index))
        REG_SUBJ_START:  cfg_r.subj_start  <= cfg_ch.wr_data;
        REG_SUBJ_END:    cfg_r.subj_end    <= cfg_ch.wr_data;
        REG_QUERY_START: cfg_r.query_start <= cfg_ch.wr_data;
        REG_QUERY_END:   cfg_r.query_end   <= cfg_ch.wr_data;
        REG_TGT_START:   cfg_r.tgt_start   <= cfg_ch.wr_data;
        REG_TGT_END:     cfg_r.tgt_end     <= cfg_ch.wr_data;
        REG_STRAND:      cfg_r.strand      <= cfg_ch.wr_data[1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Offsets for the first byte are precomputed from the registers.
  ccm_offsets u_offsets (
    .clk    (clk),
    .cfg    (cfg_r),
    .init_r (init_r)
  );

  // Advance the input stage whenever the result register can take a value.
  assign s1_go       = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_go;
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char_r <= in_ch.cigar_char;
      s1_last_r <= in_ch.last_char;
    end
  end

  // One byte of parsing: load the string state on the first byte, then
  // apply a digit or an operation to it.
  always_comb begin
    rev        = (cfg_r.strand == STRAND_REV);
    bad_strand = (cfg_r.strand > STRAND_REV);
    dig        = s1_char_r - CH_ZERO;
    is_digit   = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
    is_match   = (s1_char_r == CH_EQ) || (s1_char_r == CH_X);
    is_del     = (s1_char_r == CH_DEL);
    is_ins     = (s1_char_r == CH_INS);

    if (first_r) begin
      run_nxt    = '0;
      scur_nxt   = init_r.subj_cursor;
      qcur_nxt   = init_r.query_cursor;
      sval_nxt   = init_r.start_value;
      eval_nxt   = init_r.end_value;
      sfound_nxt = init_r.start_found;
      efound_nxt = init_r.end_found;
      if (bad_strand) begin
        held_nxt = ST_BAD_STRAND;
      end else if (init_r.start_found && init_r.end_found) begin
        held_nxt = ST_MAPPED;
      end else begin
        held_nxt = ST_PENDING;
      end
    end else begin
      run_nxt    = run_r;
      scur_nxt   = scur_r;
      qcur_nxt   = qcur_r;
      sval_nxt   = sval_r;
      eval_nxt   = eval_r;
      sfound_nxt = sfound_r;
      efound_nxt = efound_r;
      held_nxt   = held_r;
    end

    run_x10 = (run_nxt << 3) + (run_nxt << 1);
    hi      = scur_nxt + run_nxt;
    lo      = scur_nxt - run_nxt;

    if (held_nxt == ST_PENDING) begin
      if (is_digit) begin
        run_nxt = run_x10 + {{(COORD_WIDTH-4){1'b0}}, dig[3:0]};
      end else if (is_ins) begin
        qcur_nxt = qcur_nxt + run_nxt;
        run_nxt  = '0;
      end else if (is_match || is_del) begin
        if (!rev) begin
          if ((scur_nxt <= cfg_r.tgt_start) && (cfg_r.tgt_start < hi)) begin
            sval_nxt   = is_match ? qcur_nxt + (cfg_r.tgt_start - scur_nxt) : qcur_nxt;
            sfound_nxt = 1'b1;
          end
          if ((scur_nxt <= cfg_r.tgt_end) && (cfg_r.tgt_end < hi)) begin
            eval_nxt   = is_match ? qcur_nxt + (cfg_r.tgt_end - scur_nxt) : qcur_nxt;
            efound_nxt = 1'b1;
          end
          scur_nxt = hi;
        end else begin
          if ((scur_nxt > cfg_r.tgt_start) && (cfg_r.tgt_start >= lo)) begin
            eval_nxt   = is_match ? qcur_nxt + (scur_nxt - cfg_r.tgt_start) : qcur_nxt;
            efound_nxt = 1'b1;
          end
          if ((scur_nxt > cfg_r.tgt_end) && (cfg_r.tgt_end >= lo)) begin
            sval_nxt   = is_match ? qcur_nxt + (scur_nxt - cfg_r.tgt_end) - coord_t'(1)
                                  : qcur_nxt;
            sfound_nxt = 1'b1;
          end
          scur_nxt = lo;
        end
        if (is_match) begin
          qcur_nxt = qcur_nxt + run_nxt;
        end
        run_nxt = '0;
      end else begin
        held_nxt = ST_BAD_OP;
      end
      if ((held_nxt == ST_PENDING) && sfound_nxt && efound_nxt) begin
        held_nxt = ST_MAPPED;
      end
    end

    // A string that ends still pending is unresolved; rearm after the last byte.
    out_status_nxt = held_nxt;
    if (s1_last_r && (held_nxt == ST_PENDING)) begin
      out_status_nxt = ST_UNRESOLVED;
    end
    first_nxt = s1_last_r;

    if (out_status_nxt == ST_MAPPED) begin
      out_start_nxt = sval_nxt;
      out_end_nxt   = eval_nxt;
    end else begin
      out_start_nxt = '0;
      out_end_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      held_r   <= ST_PENDING;
      sfound_r <= 1'b0;
      efound_r <= 1'b0;
    end else if (s1_fire) begin
      first_r  <= first_nxt;
      held_r   <= held_nxt;
      sfound_r <= sfound_nxt;
      efound_r <= efound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      run_r  <= run_nxt;
      scur_r <= scur_nxt;
      qcur_r <= qcur_nxt;
      sval_r <= sval_nxt;
      eval_r <= eval_nxt;
    end
  end

  // Result register: load on a parsed byte, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_start_r  <= out_start_nxt;
      out_end_r    <= out_end_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mapped_start = out_start_r;
  assign out_ch.mapped_end   = out_end_r;
  assign out_ch.status       = out_status_r;

`ifndef ASSERT_OFF
  a_zero_unless_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_MAPPED)) |-> (out_start_r == '0) && (out_end_r == '0))
    else $error("mapped fields nonzero on an unmapped result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_char_r) && $stable(s1_last_r)))
    else $error("input stage lost a byte under stall");

  a_rearm_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> first_r)
    else $error("parser not rearmed after last byte");

  a_mapped_has_both: assert property (@(posedge clk) disable iff (!rst_n)
    (!first_r && (held_r == ST_MAPPED)) |-> (sfound_r && efound_r))
    else $error("mapped status without both ends found");

  a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(s1_fire))
    else $error("result appeared without a parsed byte");
`endif

endmodule

/* dv/liftover_check.sv */
`timescale 1ns / 1ps
// liftover_check: watches the request, result and register channels of the
// CIGAR coordinate mapper, predicts every result and compares them in order.
// Depends on ccm_pkg and the channel interfaces of ccm_if.
module liftover_check (
  input  logic clk,
  input  logic rst_n,
  ccm_in_if    in_ch,
  ccm_out_if   out_ch,
  ccm_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   mapped
);
  import ccm_pkg::*;

  typedef struct packed {
    coord_t  mapped_start;
    coord_t  mapped_end;
    status_t status;
  } liftover_t;

  cfg_regs_t   regs_shadow;
  liftover_t   liftover_q[$];
  int          n_fail;
  int          n_checked;
  int          n_mapped;

  // Parser shadow
  logic [15:0] run_len;
  coord_t      subj_cur;
  coord_t      qry_cur;
  coord_t      start_val;
  coord_t      end_val;
  logic        start_hit;
  logic        end_hit;
  logic        at_string_start;
  status_t     held;

  function automatic liftover_t map_byte(char_t c, logic last_byte);
    liftover_t res;
    status_t   st;
    logic      rev;
    logic      step_match;
    coord_t    sst, sen, qst, qen, tst, ten;
    coord_t    b, s, q, run_hi, run_lo;
    sst = regs_shadow.subj_start;
    sen = regs_shadow.subj_end;
    qst = regs_shadow.query_start;
    qen = regs_shadow.query_end;
    tst = regs_shadow.tgt_start;
    ten = regs_shadow.tgt_end;
    rev = (regs_shadow.strand == STRAND_REV);

    if (at_string_start) begin
      at_string_start = 1'b0;
      run_len   = '0;
      start_hit = 1'b0;
      end_hit   = 1'b0;
      start_val = '0;
      end_val   = '0;
      subj_cur  = '0;
      qry_cur   = '0;
      if (regs_shadow.strand > STRAND_REV) begin
        held = ST_BAD_STRAND;
      end else begin
        // targets outside the aligned region resolve by offset from its ends
        if (ten < sst) begin
          start_val = rev ? qen + (sst - ten) : qst - (sst - tst);
          end_val   = rev ? qen + (sst - tst) : qst - (sst - ten);
          start_hit = 1'b1;
          end_hit   = 1'b1;
        end else if (tst >= sen) begin
          start_val = rev ? qst - (ten - sen) : qen + (tst - sen);
          end_val   = rev ? qst - (tst - sen) : qen + (ten - sen);
          start_hit = 1'b1;
          end_hit   = 1'b1;
        end else if (!rev) begin
          if (tst < sst) begin
            start_val = qst - (sst - tst);
            start_hit = 1'b1;
          end
          if (ten >= sen) begin
            end_val = qen + (ten - sen);
            end_hit = 1'b1;
          end
        end else begin
          if (tst < sst) begin
            end_val = qen + (sst - tst);
            end_hit = 1'b1;
          end
          if (ten >= sen) begin
            start_val = qst - (ten - sen) - 16'sd1;
            start_hit = 1'b1;
          end
        end
        subj_cur = rev ? sen : sst;
        qry_cur  = qst;
        held = (start_hit && end_hit) ? ST_MAPPED : ST_PENDING;
      end
    end

    if (held == ST_PENDING) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        run_len = run_len * 16'd10 + 16'(c - CH_ZERO);
      end else if (c == CH_INS || c == CH_EQ || c == CH_X || c == CH_DEL) begin
        b = coord_t'(run_len);
        s = subj_cur;
        q = qry_cur;
        step_match = (c == CH_EQ || c == CH_X);
        if (c == CH_INS) begin
          qry_cur = q + b;
        end else begin
          if (!rev) begin
            run_hi = s + b;
            if (s <= tst && tst < run_hi) begin
              start_val = step_match ? q + (tst - s) : q;
              start_hit = 1'b1;
            end
            if (s <= ten && ten < run_hi) begin
              end_val = step_match ? q + (ten - s) : q;
              end_hit = 1'b1;
            end
            subj_cur = run_hi;
          end else begin
            run_lo = s - b;
            if (s > tst && tst >= run_lo) begin
              end_val = step_match ? q + (s - tst) : q;
              end_hit = 1'b1;
            end
            if (s > ten && ten >= run_lo) begin
              start_val = step_match ? q + (s - ten) - 16'sd1 : q;
              start_hit = 1'b1;
            end
            subj_cur = run_lo;
          end
          if (step_match) qry_cur = q + b;
        end
        run_len = '0;
      end else begin
        held = ST_BAD_OP;
      end
      if (held == ST_PENDING && start_hit && end_hit) held = ST_MAPPED;
    end

    st = held;
    if (last_byte) begin
      if (st == ST_PENDING) st = ST_UNRESOLVED;
      at_string_start = 1'b1;
    end
    res.status       = st;
    res.mapped_start = (st == ST_MAPPED) ? start_val : '0;
    res.mapped_end   = (st == ST_MAPPED) ? end_val : '0;
    return res;
  endfunction

  function automatic void check_field(string field, logic signed [16:0] want_v,
                                      logic signed [16:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : track
    liftover_t want;
    if (!rst_n) begin
      regs_shadow     = '0;
      run_len         = '0;
      subj_cur        = '0;
      qry_cur         = '0;
      start_val       = '0;
      end_val         = '0;
      start_hit       = 1'b0;
      end_hit         = 1'b0;
      at_string_start = 1'b1;
      held            = ST_PENDING;
      liftover_q.delete();
      n_fail          = 0;
      n_checked       = 0;
      n_mapped        = 0;
    end else begin
      // compare first: a result never belongs to a request taken at this edge
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (out_ch.status == ST_MAPPED) n_mapped++;
        if (liftover_q.size() == 0) begin
          $display("%0t: unexpected result start %0d end %0d status %0d", $time,
                   out_ch.mapped_start, out_ch.mapped_end, out_ch.status);
          n_fail++;
        end else begin
          want = liftover_q.pop_front();
          check_field("mapped_start", 17'(want.mapped_start), 17'(out_ch.mapped_start));
          check_field("mapped_end", 17'(want.mapped_end), 17'(out_ch.mapped_end));
          check_field("status", 17'(want.status), 17'(out_ch.status));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_SUBJ_START:  regs_shadow.subj_start  = cfg_ch.wr_data;
          REG_SUBJ_END:    regs_shadow.subj_end    = cfg_ch.wr_data;
          REG_QUERY_START: regs_shadow.query_start = cfg_ch.wr_data;
          REG_QUERY_END:   regs_shadow.query_end   = cfg_ch.wr_data;
          REG_TGT_START:   regs_shadow.tgt_start   = cfg_ch.wr_data;
          REG_TGT_END:     regs_shadow.tgt_end     = cfg_ch.wr_data;
          REG_STRAND:      regs_shadow.strand      = cfg_ch.wr_data[1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        liftover_q.push_back(map_byte(in_ch.cigar_char, in_ch.last_char));
      end
    end
    fail_count <= n_fail;
    pending    <= liftover_q.size();
    checked    <= n_checked;
    mapped     <= n_mapped;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives CIGAR strings and register settings into the coordinate
// mapper and gives the verdict. Depends on ccm_pkg, ccm_if, liftover_check.
module testbench;
  import ccm_pkg::*;

  localparam int ITEM_TARGET   = 1550;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;

  // Index past the register file: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Strand code with the top bit set is rejected by the block
  localparam logic [1:0] STRAND_BAD = 2'd2;

  logic clk = 1'b0;
  logic rst_n;

  ccm_in_if  in_ch ();
  ccm_out_if out_ch ();
  ccm_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked;
  int mapped;

  cigar_coordinate_mapper i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  liftover_check i_liftover_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .mapped     (mapped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run if the block stops answering
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("cigar_coordinate_mapper verification failed");
      $finish;
    end
  end

  // Result side: rotate a stall pattern and reload it when pat_age runs down.
  // A quarter of the patterns are all ones, giving stretches with no stall.
  logic [31:0] stall_pat = '1;
  int          pat_age = 0;
  always @(posedge clk) begin
    if (pat_age == 0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
      pat_age   <= 47;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[31:1]};
      pat_age   <= pat_age - 1;
    end
    out_ch.ready <= stall_pat[0];
  end

  // Request side state
  char_t  cigar_q[$];
  coord_t next_cfg [0:6];
  int     burst_left = 0;
  bit     steady = 1'b0;
  int     sent_requests = 0;
  int     n_strings = 0;
  int     n_phases = 0;

  // Send cigar_q as one string, the last byte flagged. Requests go out in
  // bursts; between bursts drop valid for a random gap unless the phase
  // runs steady.
  task automatic send_cigar();
    int gap;
    for (int i = 0; i < cigar_q.size(); i++) begin
      if (burst_left == 0) begin
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      in_ch.valid      <= 1'b1;
      in_ch.cigar_char <= cigar_q[i];
      in_ch.last_char  <= (i == cigar_q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      burst_left--;
      sent_requests++;
    end
    n_strings++;
  endtask

  task automatic send_text(string s);
    cigar_q.delete();
    for (int k = 0; k < s.len(); k++) cigar_q.push_back(s[k]);
    send_cigar();
  endtask

  task automatic load_region(coord_t sst, coord_t sen, coord_t qst, coord_t qen,
                             coord_t tst, coord_t ten, logic [1:0] strand);
    next_cfg[REG_SUBJ_START]  = sst;
    next_cfg[REG_SUBJ_END]    = sen;
    next_cfg[REG_QUERY_START] = qst;
    next_cfg[REG_QUERY_END]   = qen;
    next_cfg[REG_TGT_START]   = tst;
    next_cfg[REG_TGT_END]     = ten;
    next_cfg[REG_STRAND]      = coord_t'(strand);
  endtask

  // Drain the block, then write next_cfg into every register back to back.
  // Hold off SETTLE_CYCLES on each side: writes reach strings started later.
  task automatic reconfigure(bit poke_unused);
    logic [CFG_IDX_W-1:0] idx_q[$];
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int r = REG_SUBJ_START; r <= REG_STRAND; r++) idx_q.push_back(r[CFG_IDX_W-1:0]);
    if (poke_unused) idx_q.push_back(REG_UNUSED);
    foreach (idx_q[k]) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= idx_q[k];
      if (idx_q[k] == REG_UNUSED) begin
        cfg_ch.wr_data <= coord_t'($urandom);
      end else begin
        cfg_ch.wr_data <= next_cfg[idx_q[k]];
      end
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
    steady     = ($urandom_range(0, 4) == 0);
    n_phases++;
  endtask

  initial begin
    int         mode;
    int         span;
    int         kind;
    int         pick;
    int         run;
    string      digits;
    coord_t     base;
    logic [1:0] strand_pick;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cigar_char = '0;
    in_ch.last_char  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wr_data   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: both targets sit at the aligned end, so the
    // first byte maps by offset and nothing is parsed.
    send_text("1=");

    // Forward strand, targets inside a ten-base region
    load_region(100, 110, 1000, 1012, 103, 107, STRAND_FWD);
    reconfigure(1'b0);
    send_text("10=");       // interpolate both ends in one match run
    send_text("2D1I8X");    // deletion, insertion, mismatch run
    send_text("5Q1=");      // bad operation byte, then ignored bytes
    send_text("3=");        // runs out before the targets
    cigar_q = {8'hFF};      // lone non-ASCII byte
    send_cigar();
    cigar_q = {8'h00};
    send_cigar();

    // Reverse strand over the same region
    load_region(100, 110, 1000, 1012, 103, 107, STRAND_REV);
    reconfigure(1'b0);
    send_text("4=2D4X");

    // Invalid strand; also poke the index past the register file
    load_region(100, 110, 1000, 1012, 103, 107, STRAND_BAD);
    reconfigure(1'b1);
    send_text("5=");

    // Random phases: new register set, then a handful of strings each
    while (sent_requests < ITEM_TARGET) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        // Plausible alignment with targets around it; now and then place it
        // at the top of the range so the subject end may wrap.
        base = ($urandom_range(0, 9) == 0) ? coord_t'(16'sh7FFF - $urandom_range(0, 100))
                                           : coord_t'($urandom_range(0, 400) - 200);
        span = $urandom_range(5, 150);
        next_cfg[REG_SUBJ_START]  = base;
        next_cfg[REG_SUBJ_END]    = coord_t'(base + span);
        next_cfg[REG_QUERY_START] = coord_t'($urandom);
        next_cfg[REG_QUERY_END]   = coord_t'(next_cfg[REG_QUERY_START]
                                             + $urandom_range(0, 200));
        next_cfg[REG_TGT_START]   = coord_t'(base + $urandom_range(0, span + 40) - 20);
        next_cfg[REG_TGT_END]     = coord_t'(next_cfg[REG_TGT_START]
                                             + $urandom_range(0, 40) - 5);
      end else if (mode < 85) begin
        for (int r = REG_SUBJ_START; r <= REG_TGT_END; r++) next_cfg[r] = coord_t'($urandom);
      end else begin
        // Extremes of the coordinate range
        for (int r = REG_SUBJ_START; r <= REG_TGT_END; r++) begin
          case ($urandom_range(0, 4))
            0:       next_cfg[r] = 16'sh8000;
            1:       next_cfg[r] = 16'sh7FFF;
            2:       next_cfg[r] = '0;
            3:       next_cfg[r] = '1;
            default: next_cfg[r] = coord_t'($urandom);
          endcase
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        strand_pick = STRAND_FWD;
      end else if (pick < 90) begin
        strand_pick = STRAND_REV;
      end else begin
        strand_pick = {1'b1, 1'($urandom)};
      end
      // upper data bits of the strand write are don't-care: randomize them
      next_cfg[REG_STRAND] = coord_t'({$urandom_range(0, 16383), strand_pick});
      reconfigure($urandom_range(0, 9) == 0);

      repeat ($urandom_range(3, 10)) begin
        cigar_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
          // noise: arbitrary bytes
          repeat ($urandom_range(1, 6)) cigar_q.push_back(char_t'($urandom));
        end else begin
          repeat ($urandom_range(1, 8)) begin
            // run length: mostly short, some missing, zero, or long enough to wrap
            pick = $urandom_range(0, 99);
            if (pick >= 5) begin
              run = (pick < 10) ? $urandom_range(0, 99999) :
                    (pick < 14) ? 0 : $urandom_range(1, 25);
              digits = $sformatf("%0d", run);
              for (int k = 0; k < digits.len(); k++) cigar_q.push_back(digits[k]);
            end
            case ($urandom_range(0, 9))
              0, 1, 2: cigar_q.push_back(CH_EQ);
              3, 4:    cigar_q.push_back(CH_X);
              5, 6:    cigar_q.push_back(CH_INS);
              7, 8:    cigar_q.push_back(CH_DEL);
              default: begin
                if ($urandom_range(0, 4) == 0) begin
                  cigar_q.push_back(char_t'($urandom));
                end else begin
                  cigar_q.push_back(CH_EQ);
                end
              end
            endcase
          end
          // some strings stop on a dangling run length
          if (kind < 20) cigar_q.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
        end
        send_cigar();
      end
    end

    // Drain and give the block time to show any stray result
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d register phases, %0d CIGAR strings, %0d byte requests.",
             n_phases, n_strings, sent_requests);
    $display("Compared %0d results, %0d of them mapped; %0d mismatches.",
             checked, mapped, fail_count);
    if (fail_count == 0) begin
      $display("cigar_coordinate_mapper verification clean");
    end else begin
      $display("cigar_coordinate_mapper verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ccm_pkg.sv
rtl/ccm_if.sv
rtl/ccm_offsets.sv
rtl/cigar_coordinate_mapper.sv
dv/liftover_check.sv
dv/testbench.sv
